// ===== src/assert_macros.svh =====
// Assertion macros shared by the mono8 peak normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== src/mpn_pkg.sv =====
// Package: types and constants of the mono8 peak normalizer.
`timescale 1ns / 1ps

package mpn_pkg;

  // Pixel formats
  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_YUYV = 2'd1;
  localparam logic [1:0] FMT_Y16  = 2'd2;

  // Register bus geometry and register indexes
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_FMT_SEL    = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  // Reset values
  localparam logic [1:0]  FMT_SEL_RESET    = FMT_GREY;
  localparam logic [12:0] LINE_WIDTH_RESET = 13'd640;
  localparam logic [15:0] PEAK_FLOOR       = 16'd255;
  localparam logic [16:0] GAIN_RESET       = 17'h10000;

  // Gain divide: (255 << 16) / peak, one quotient bit per step
  localparam logic [23:0] SCALE_NUM = 24'hFF0000;
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam int unsigned DEFAULT_MAX_LINE_WIDTH = 4096;

  typedef struct packed {
    logic        mode;
    logic [15:0] pixel_word;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mono_pixel;
    logic       last_pixel;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic busy;
    logic div_load;
    logic div_step;
    logic div_commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close_frame;
  } status_t;

endpackage

// ===== src/mpn_regs.sv =====
// Configuration registers of the normalizer behind an APB-style port.
`timescale 1ns / 1ps

module mpn_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mpn_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mpn_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mpn_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [1:0]                       fmt_sel_o,
  output logic [12:0]                      line_width_o
);
  import mpn_pkg::*;

  logic [1:0]  fmt_sel_q, fmt_sel_d;
  logic [12:0] line_width_q, line_width_d;
  logic        reg_index;
  logic        wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;

  // Decode the write request
  always_comb begin
    fmt_sel_d    = fmt_sel_q;
    line_width_d = line_width_q;
    if (wr_en) begin
      case (reg_index)
        REG_FMT_SEL:    fmt_sel_d    = pwdata[1:0];
        REG_LINE_WIDTH: line_width_d = pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_sel_q    <= FMT_SEL_RESET;
      line_width_q <= LINE_WIDTH_RESET;
    end else begin
      fmt_sel_q    <= fmt_sel_d;
      line_width_q <= line_width_d;
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_index)
      REG_FMT_SEL:    prdata = {{(APB_DATA_W-2){1'b0}}, fmt_sel_q};
      REG_LINE_WIDTH: prdata = {{(APB_DATA_W-13){1'b0}}, line_width_q};
      default:        prdata = '0;
    endcase
  end

  assign fmt_sel_o    = fmt_sel_q;
  assign line_width_o = line_width_q;

endmodule

// ===== src/mpn_ctrl.sv =====
// Controller: sequences the gain divide after a measure frame closes.
`timescale 1ns / 1ps

module mpn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpn_pkg::status_t status_i,
  output mpn_pkg::cmd_t    cmd_o
);
  import mpn_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_WRITE  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.busy = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (status_i.close_frame) begin
          cmd_o.div_load = 1'b1;
          step_d         = '0;
          state_d        = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.div_commit = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== src/mpn_dpath.sv =====
// Datapath: peak measure, gain divider and two-stage convert pipe.
`timescale 1ns / 1ps

module mpn_dpath #(
  parameter int unsigned MAX_LINE_WIDTH = mpn_pkg::DEFAULT_MAX_LINE_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         fmt_sel_i,
  input  logic [12:0]        line_width_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpn_pkg::in_item_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mpn_pkg::out_item_t out_rsp_o,
  input  mpn_pkg::cmd_t      cmd_i,
  output mpn_pkg::status_t   status_o
);
  import mpn_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned EffW = $clog2(MAX_LINE_WIDTH + 1);

  // Measure state
  logic [15:0]     peak_q, peak_d;
  logic [15:0]     rmax_q, rmax_d;
  logic [16:0]     gain_q, gain_d;
  logic [CntW-1:0] col_q, col_d;

  // Divider
  logic [15:0] rem_q, rem_d;
  logic [23:0] quo_q, quo_d;
  logic [16:0] rem_sh;
  logic        rem_ge;

  // Pipe stages
  logic        a_valid_q, a_valid_d;
  logic [32:0] a_prod_q;
  logic [7:0]  a_byte_q;
  logic        a_y16_q;
  logic        a_last_q;
  logic        b_valid_q, b_valid_d;
  out_item_t   b_item_q;

  logic        y16;
  logic        accept, conv, meas;
  logic        a_adv, a_free, b_free;
  logic [32:0] prod;
  logic [7:0]  sat_byte;

  logic [EffW-1:0] eff_w, col_ext, col_cur, col_inc, col_nxt;
  logic            sample;
  logic [15:0]     rmax_new, fmax, decayed, peak_new;
  logic [21:0]     peak_x63;

  assign y16 = !(fmt_sel_i inside {FMT_GREY, FMT_YUYV});

  // Handshake and pipe flow
  assign b_free     = !b_valid_q || !out_stall_i;
  assign a_adv      = a_valid_q && b_free;
  assign a_free     = !a_valid_q || b_free;
  assign in_stall_o = cmd_i.busy || !a_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign conv       = accept && in_req_i.mode;
  assign meas       = accept && !in_req_i.mode && y16;

  assign status_o.close_frame = meas && in_req_i.frame_end;

  // Column phase within the row
  always_comb begin
    if (32'(line_width_i) > 32'(MAX_LINE_WIDTH)) begin
      eff_w = EffW'(MAX_LINE_WIDTH);
    end else begin
      eff_w = EffW'(line_width_i);
    end
    col_ext = EffW'(col_q);
    col_cur = (col_ext >= eff_w) ? '0 : col_ext;
    sample  = (col_cur[1:0] == 2'b00);
    col_inc = col_cur + 1'b1;
    col_nxt = (col_inc >= eff_w) ? '0 : col_inc;
  end

  // Frame peak with floor and decay of the old peak by 63/64
  always_comb begin
    rmax_new = (sample && (in_req_i.pixel_word > rmax_q)) ? in_req_i.pixel_word : rmax_q;
    fmax     = (rmax_new > PEAK_FLOOR) ? rmax_new : PEAK_FLOOR;
    peak_x63 = {peak_q, 6'b0} - {6'b0, peak_q};
    decayed  = peak_x63[21:6];
    peak_new = (fmax > decayed) ? fmax : decayed;
  end

  // Update measure state
  always_comb begin
    peak_d = peak_q;
    rmax_d = rmax_q;
    col_d  = col_q;
    if (meas) begin
      if (in_req_i.frame_end) begin
        peak_d = peak_new;
        rmax_d = '0;
        col_d  = '0;
      end else begin
        rmax_d = rmax_new;
        col_d  = CntW'(col_nxt);
      end
    end
  end

  // Restoring divide, one quotient bit per step
  assign rem_sh = {rem_q, quo_q[23]};
  assign rem_ge = (rem_sh >= {1'b0, peak_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    gain_d = gain_q;
    if (cmd_i.div_load) begin
      rem_d = '0;
      quo_d = SCALE_NUM;
    end else if (cmd_i.div_step) begin
      rem_d = rem_ge ? 16'(rem_sh - {1'b0, peak_q}) : rem_sh[15:0];
      quo_d = {quo_q[22:0], rem_ge};
    end
    if (cmd_i.div_commit) begin
      gain_d = quo_q[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= PEAK_FLOOR;
      rmax_q <= '0;
      gain_q <= GAIN_RESET;
      col_q  <= '0;
    end else begin
      peak_q <= peak_d;
      rmax_q <= rmax_d;
      gain_q <= gain_d;
      col_q  <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Stage A: scale the sample by the gain
  assign prod = 33'(in_req_i.pixel_word) * 33'(gain_q);

  always_comb begin
    a_valid_d = a_valid_q;
    if (conv) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv) begin
      a_prod_q <= prod;
      a_byte_q <= in_req_i.pixel_word[7:0];
      a_y16_q  <= y16;
      a_last_q <= in_req_i.frame_end;
    end
  end

  // Stage B: saturate and hold the result
  assign sat_byte = (a_prod_q[32:16] > 17'd255) ? 8'hFF : a_prod_q[23:16];

  always_comb begin
    b_valid_d = b_valid_q;
    if (a_adv) begin
      b_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_item_q.mono_pixel <= a_y16_q ? sat_byte : a_byte_q;
      b_item_q.last_pixel <= a_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_rsp_o   = b_item_q;

endmodule

// ===== src/mono8_peak_normalizer_unit.sv =====
// Top level of the mono8 peak normalizer: registers, controller, datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts grey, YUYV or Y16 pixels to 8-bit mono. Requests may follow
// each other in every cycle unless in_stall_o is high (gain update, or
// stage B stalled with stage A full); a converted pixel reaches the
// output through stage A and stage B, a two-register output pipe that
// still takes one more request while a result waits.
// A measure request carrying frame_end (Y16 or spare format) starts the
// gain update: a restoring divider forms (255 << 16) / peak one quotient
// bit per cycle, so input is stalled through the 24 divide steps and the
// write-back (the load shares the cycle that takes the request) before
// the next request is taken.
module mono8_peak_normalizer_unit #(
  parameter int unsigned MAX_LINE_WIDTH = mpn_pkg::DEFAULT_MAX_LINE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mpn_pkg::in_item_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mpn_pkg::out_item_t             out_rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpn_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpn_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpn_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mpn_pkg::*;

  logic [1:0]  fmt_sel;
  logic [12:0] line_width;
  cmd_t        cmd;
  status_t     status;

  mpn_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fmt_sel_o    (fmt_sel),
    .line_width_o (line_width)
  );

  mpn_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mpn_dpath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fmt_sel_i      (fmt_sel),
    .line_width_i   (line_width),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_req_i       (in_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_rsp_o      (out_rsp_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  // A closed measure frame must start the divide
  `ASSERT_ALWAYS(a_close_starts_divide, status.close_frame |=> cmd.busy, "divide not started")
  // No request may slip in while the gain is being recomputed
  `ASSERT_NEVER(a_no_accept_busy, cmd.busy && in_valid_i && !in_stall_o, "request taken while busy")
  // The gain is written back once per divide
  `ASSERT_ALWAYS(a_single_commit, cmd.div_commit |=> !cmd.div_commit, "repeated gain write")

endmodule

// ===== dv/mono8_peak_normalizer_unit_tb.sv =====
// Testbench of the mono8 peak normalizer: predicted pixels checked against the block.
`timescale 1ns / 1ps

module mono8_peak_normalizer_unit_tb;
  import mpn_pkg::*;

  localparam logic        MODE_MEASURE  = 1'b0;
  localparam logic        MODE_CONVERT  = 1'b1;
  localparam logic [1:0]  FMT_SPARE     = 2'd3;
  localparam int unsigned MAX_W         = DEFAULT_MAX_LINE_WIDTH;
  localparam int unsigned DECAY_NUM     = 63;
  localparam int unsigned DECAY_DEN     = 64;
  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PRINT_LIMIT   = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_req   = '0;
  logic      out_valid;
  logic      rx_stall = 1'b0;
  logic      rx_hold  = 1'b0;
  logic      out_stall;
  out_item_t out_rsp;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow registers and state of the normalizer
  logic [1:0]  fmt_reg;
  logic [12:0] width_reg;
  logic [15:0] peak_lvl;
  logic [15:0] run_max;
  logic [16:0] gain;
  logic [12:0] col_cnt;

  out_item_t   pending_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned pixels_counted = 0;
  int unsigned cycle_count    = 0;
  int unsigned rx_wait        = 0;
  bit          tx_idle_en     = 1'b0;
  bit          rx_idle_en     = 1'b0;
  bit          tx_live        = 1'b0;

  assign out_stall = rx_stall | rx_hold;

  mono8_peak_normalizer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mono8_peak_normalizer_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic void reset_shadow();
    fmt_reg   = FMT_SEL_RESET;
    width_reg = LINE_WIDTH_RESET;
    peak_lvl  = PEAK_FLOOR;
    run_max   = '0;
    gain      = GAIN_RESET;
    col_cnt   = '0;
  endfunction

  // Update peak and gain at the end of a measured frame
  function automatic void close_frame_gain();
    int unsigned fmax, decayed, pk;
    fmax    = 32'((run_max > PEAK_FLOOR) ? run_max : PEAK_FLOOR);
    decayed = (peak_lvl * DECAY_NUM) / DECAY_DEN;
    pk      = (fmax > decayed ? fmax : decayed) & 32'hFFFF;
    if (pk < PEAK_FLOOR) pk = PEAK_FLOOR;
    peak_lvl = pk[15:0];
    gain     = 17'(SCALE_NUM / pk);
    run_max  = '0;
    col_cnt  = '0;
  endfunction

  // Advance the shadow state by one request; queue the pixel it yields
  function automatic void normalize_pixel(input in_item_t req);
    logic        y16;
    logic [12:0] w;
    logic [32:0] prod;
    out_item_t   px;
    y16 = !(fmt_reg == FMT_GREY || fmt_reg == FMT_YUYV);
    if (req.mode == MODE_MEASURE) begin
      if (y16) begin
        w = (width_reg > MAX_W) ? 13'(MAX_W) : width_reg;
        if (col_cnt >= w) col_cnt = '0;
        if (col_cnt[1:0] == 2'b00 && req.pixel_word > run_max) run_max = req.pixel_word;
        col_cnt++;
        if (col_cnt >= w) col_cnt = '0;
        if (req.frame_end) close_frame_gain();
      end
    end else begin
      if (y16) begin
        prod = 33'(req.pixel_word) * 33'(gain);
        px.mono_pixel = (prod[32:16] > 17'd255) ? 8'hFF : prod[23:16];
      end else begin
        px.mono_pixel = req.pixel_word[7:0];
      end
      px.last_pixel = req.frame_end;
      pending_pixels.insert(pending_pixels.size(), px);
    end
  endfunction

  // Drop valid once the last request is taken
  task automatic tx_quiet();
    if (tx_live) begin
      in_valid <= 1'b0;
      tx_live = 1'b0;
    end
  endtask

  // Offer one pixel request and wait until it is taken
  task automatic send_pixel(input logic mode, input logic [15:0] word, input logic fend);
    int unsigned gap;
    in_item_t    req;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      tx_quiet();
      repeat (gap) @(posedge clk_i);
    end
    req.mode       = mode;
    req.pixel_word = word;
    req.frame_end  = fend;
    in_valid <= 1'b1;
    in_req   <= req;
    tx_live = 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (mode == MODE_CONVERT || !(fmt_reg == FMT_GREY || fmt_reg == FMT_YUYV))
      pixels_counted++;
    normalize_pixel(req);
  endtask

  // One APB transfer; the bus is left selected for a back-to-back transfer
  task automatic apb_transfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // Write a register, read it back, then release the bus
  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] rdata, want;
    addr = APB_ADDR_W'({idx, 2'b00});
    if (idx == REG_FMT_SEL) begin
      fmt_reg = value[1:0];
      want    = {30'd0, value[1:0]};
    end else begin
      width_reg = value[12:0];
      want      = {19'd0, value[12:0]};
    end
    apb_transfer(1'b1, addr, value, rdata);
    apb_transfer(1'b0, addr, '0, rdata);
    if (rdata !== want) report_mismatch("register readback", int'(rdata), int'(want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold the sender until every predicted pixel is out, then let the divider settle
  task automatic wait_drained();
    int unsigned waited;
    tx_quiet();
    waited = 0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      report_mismatch("pixels never delivered", pending_pixels.size(), 0);
      pending_pixels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    w = 16'($urandom);
    return w >> $urandom_range(0, 16);
  endfunction

  // Receiver: stall a random number of cycles after each taken pixel
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned nxt;
    if (!rst_ni) begin
      rx_stall <= 1'b0;
      rx_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      nxt = rx_idle_en ? $urandom_range(0, 15) : 0;
      rx_wait  <= nxt;
      rx_stall <= (nxt != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait  <= 0;
      rx_stall <= 1'b0;
    end
  end

  // Compare each taken pixel with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want_px;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", int'(out_rsp.mono_pixel), 0);
      end else begin
        want_px = pending_pixels[0];
        pending_pixels.delete(0);
        if (out_rsp.mono_pixel !== want_px.mono_pixel)
          report_mismatch("mono_pixel", int'(out_rsp.mono_pixel), int'(want_px.mono_pixel));
        if (out_rsp.last_pixel !== want_px.last_pixel)
          report_mismatch("last_pixel", int'(out_rsp.last_pixel), int'(want_px.last_pixel));
      end
    end
  end

  // Grey and YUYV pass the low byte; measure requests are ignored there
  task automatic test_pass_through();
    write_reg(REG_FMT_SEL, 32'(FMT_GREY));
    send_pixel(MODE_CONVERT, 16'h0000, 1'b0);
    send_pixel(MODE_CONVERT, 16'hFFFF, 1'b0);
    send_pixel(MODE_MEASURE, 16'hFF00, 1'b1);
    send_pixel(MODE_CONVERT, 16'hFF00, 1'b1);
    wait_drained();
    write_reg(REG_FMT_SEL, 32'(FMT_YUYV));
    send_pixel(MODE_CONVERT, 16'hA55A, 1'b0);
    send_pixel(MODE_MEASURE, 16'hFFFF, 1'b1);
    send_pixel(MODE_CONVERT, 16'h5AA5, 1'b1);
    wait_drained();
  endtask

  // Y16 gain: floor gain, full-scale peak, decay, and the spare format code
  task automatic test_y16_gain();
    write_reg(REG_FMT_SEL, 32'(FMT_Y16));
    write_reg(REG_LINE_WIDTH, 4);
    send_pixel(MODE_CONVERT, 16'h00FF, 1'b0);
    send_pixel(MODE_CONVERT, 16'h0100, 1'b1);
    send_pixel(MODE_MEASURE, 16'hFFFF, 1'b0);
    send_pixel(MODE_MEASURE, 16'h1234, 1'b0);
    send_pixel(MODE_MEASURE, 16'h0000, 1'b1);
    send_pixel(MODE_CONVERT, 16'hFFFF, 1'b0);
    send_pixel(MODE_CONVERT, 16'h8000, 1'b1);
    wait_drained();
    write_reg(REG_FMT_SEL, 32'(FMT_SPARE));
    send_pixel(MODE_MEASURE, 16'h0010, 1'b1);
    send_pixel(MODE_CONVERT, 16'hFFFF, 1'b1);
    wait_drained();
  endtask

  // Line width: zero, clamp above the maximum, a change mid-row, and writes of the maximum and of one
  task automatic test_line_width();
    write_reg(REG_FMT_SEL, 32'(FMT_Y16));
    write_reg(REG_LINE_WIDTH, 0);
    send_pixel(MODE_MEASURE, 16'h0100, 1'b0);
    send_pixel(MODE_MEASURE, 16'h7000, 1'b1);
    send_pixel(MODE_CONVERT, 16'h4000, 1'b1);
    wait_drained();
    write_reg(REG_LINE_WIDTH, 32'h1FFF);
    send_pixel(MODE_MEASURE, 16'h0300, 1'b0);
    send_pixel(MODE_MEASURE, 16'hF000, 1'b1);
    wait_drained();
    write_reg(REG_LINE_WIDTH, 8);
    repeat (6) send_pixel(MODE_MEASURE, 16'h0200, 1'b0);
    wait_drained();
    write_reg(REG_LINE_WIDTH, 4);
    send_pixel(MODE_MEASURE, 16'hE000, 1'b1);
    send_pixel(MODE_CONVERT, 16'hC000, 1'b1);
    wait_drained();
    write_reg(REG_LINE_WIDTH, MAX_W);
    write_reg(REG_LINE_WIDTH, 1);
    wait_drained();
  endtask

  // Receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_reg(REG_FMT_SEL, 32'(FMT_GREY));
    fork
      hold_receiver(300);
    join_none
    repeat (40) send_pixel(MODE_CONVERT, rand_word(), $urandom_range(0, 7) == 0);
    wait_drained();
    write_reg(REG_FMT_SEL, 32'(FMT_Y16));
    write_reg(REG_LINE_WIDTH, 5);
    fork
      hold_receiver(120);
    join_none
    repeat (4) send_pixel(MODE_CONVERT, rand_word(), 1'b0);
    repeat (5) send_pixel(MODE_MEASURE, rand_word(), 1'b0);
    send_pixel(MODE_MEASURE, rand_word(), 1'b1);
    repeat (10) send_pixel(MODE_CONVERT, rand_word(), 1'b0);
    wait_drained();
  endtask

  // Random frames: mostly measure-then-convert Y16 pairs, some noise
  task automatic test_random();
    logic [1:0]  fmt;
    logic [12:0] w;
    int unsigned len;
    logic [15:0] frame_px[$];
    while (pixels_counted < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       fmt = FMT_GREY;
        1:       fmt = FMT_YUYV;
        5:       fmt = FMT_SPARE;
        default: fmt = FMT_Y16;
      endcase
      case ($urandom_range(0, 9))
        0:       w = 13'd0;
        1:       w = 13'(MAX_W);
        2:       w = 13'h1FFF;
        3:       w = 13'($urandom_range(13, 8191));
        default: w = 13'($urandom_range(1, 12));
      endcase
      write_reg(REG_FMT_SEL, 32'(fmt));
      write_reg(REG_LINE_WIDTH, 32'(w));
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0) begin
          // Noise: any mode, any frame end
          repeat (len)
            send_pixel(1'($urandom_range(0, 1)), rand_word(), $urandom_range(0, 7) == 0);
        end else begin
          frame_px.delete();
          repeat (len) frame_px.insert(frame_px.size(), rand_word());
          if (fmt == FMT_Y16 || fmt == FMT_SPARE)
            foreach (frame_px[k])
              send_pixel(MODE_MEASURE, frame_px[k], k == len - 1);
          foreach (frame_px[k])
            send_pixel(MODE_CONVERT, frame_px[k], k == len - 1);
        end
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_pass_through();
    test_y16_gain();
    test_line_width();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("mono8_peak_normalizer_unit_tb: done, clean");
    end else begin
      $display("mono8_peak_normalizer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
